>>> rtl/spcp_pkg.sv
`timescale 1ns / 1ps
package spcp_pkg;

  // coordinate and difference widths
  localparam int CW      = 24;
  localparam int DW      = CW + 1;
  // one coordinate product, and a dot product of three of them
  localparam int PROD_W  = 2 * DW;
  localparam int DOTW    = PROD_W + 2;
  // product of two dot products, and the halves used to build it
  localparam int PW      = 2 * DOTW;
  localparam int HW      = DOTW / 2;
  // segment parameters: unsigned Q0.PF plus one integer bit
  localparam int PF      = 16;
  localparam int SW      = PF + 1;
  localparam int THR_W   = 16;
  localparam int DIST_W  = 50;
  // point scaling product: signed difference times zero-extended parameter
  localparam int SPW     = DW + SW + 1;
  localparam int SQW     = 2 * DW;

  localparam int MUL_LAT = 2;
  localparam int DIV_LAT = PF + 1;

  localparam logic [SW-1:0] ONE = {1'b1, {PF{1'b0}}};

endpackage

>>> rtl/segment_pair_closest_points.sv
`timescale 1ns / 1ps
// Closest points between two 3D segments.
//
// Requests: drive the twelve endpoint coordinates and raise start; a request
// is taken at each rising edge where start is high and busy is low. busy
// stays low, so a new request may be issued in every cycle.
// Results: one per request, in request order, shown for one cycle with
// result_valid_o high: s, t, both closest points and the squared distance.
// The receiver cannot hold results off and the pipeline never stalls.
// Throughput is one request per cycle. The path holds two 17-stage
// quotient pipelines (a front stage, then one restoring step per stage),
// which run in series because the clamp test on t needs the first
// quotient, each with two-stage wide multipliers ahead of it.
// Configuration: cfg_we_i writes degenerate_threshold; write it only while
// no request is in flight.
// Reset: rst_ni clears the threshold and all valid bits; nothing is
// returned for requests that were in flight.
module segment_pair_closest_points (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [spcp_pkg::THR_W-1:0]          cfg_wdata_i,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [spcp_pkg::CW-1:0]      seg1_start_x_i,
  input  logic signed [spcp_pkg::CW-1:0]      seg1_start_y_i,
  input  logic signed [spcp_pkg::CW-1:0]      seg1_start_z_i,
  input  logic signed [spcp_pkg::CW-1:0]      seg1_end_x_i,
  input  logic signed [spcp_pkg::CW-1:0]      seg1_end_y_i,
  input  logic signed [spcp_pkg::CW-1:0]      seg1_end_z_i,
  input  logic signed [spcp_pkg::CW-1:0]      seg2_start_x_i,
  input  logic signed [spcp_pkg::CW-1:0]      seg2_start_y_i,
  input  logic signed [spcp_pkg::CW-1:0]      seg2_start_z_i,
  input  logic signed [spcp_pkg::CW-1:0]      seg2_end_x_i,
  input  logic signed [spcp_pkg::CW-1:0]      seg2_end_y_i,
  input  logic signed [spcp_pkg::CW-1:0]      seg2_end_z_i,
  output logic                                result_valid_o,
  output logic [spcp_pkg::SW-1:0]             param_s_o,
  output logic [spcp_pkg::SW-1:0]             param_t_o,
  output logic signed [spcp_pkg::CW-1:0]      closest1_x_o,
  output logic signed [spcp_pkg::CW-1:0]      closest1_y_o,
  output logic signed [spcp_pkg::CW-1:0]      closest1_z_o,
  output logic signed [spcp_pkg::CW-1:0]      closest2_x_o,
  output logic signed [spcp_pkg::CW-1:0]      closest2_y_o,
  output logic signed [spcp_pkg::CW-1:0]      closest2_z_o,
  output logic [spcp_pkg::DIST_W-1:0]         distance_squared_o
);
  import spcp_pkg::*;

  // how s and t are picked once the second quotient is out
  typedef enum logic [2:0] {
    SEL_NONE,   // both segments are points
    SEL_DEG1,   // first is a point: t from first quotient
    SEL_DEG2,   // second is a point: s from first quotient
    SEL_T0,     // t clamped to zero, s recomputed
    SEL_T1,     // t clamped to one, s recomputed
    SEL_T       // t from second quotient
  } sel_e;

  typedef struct packed {
    logic                 vld;
    logic                 deg1;
    logic                 deg2;
    sel_e                 sel;
    logic [2:0][CW-1:0]   p1;
    logic [2:0][CW-1:0]   p2;
    logic [2:0][DW-1:0]   d1;
    logic [2:0][DW-1:0]   d2;
    logic [2:0][DW-1:0]   r;
    logic [DOTW-1:0]      a;
    logic [DOTW-1:0]      b;
    logic [DOTW-1:0]      c;
    logic [DOTW-1:0]      e;
    logic [DOTW-1:0]      f;
    logic [SW-1:0]        q1;
    logic [SW-1:0]        s;
    logic [SW-1:0]        t;
  } ctx_t;

  typedef struct packed {
    logic                 vld;
    logic [SW-1:0]        s;
    logic [SW-1:0]        t;
    logic [2:0][CW-1:0]   c1;
    logic [2:0][CW-1:0]   c2;
  } pt_t;

  function automatic logic [PW-1:0] ext_dot(input logic [DOTW-1:0] v);
    ext_dot = {{(PW-DOTW){v[DOTW-1]}}, v};
  endfunction

  function automatic logic [DOTW-1:0] sum3(input logic [PROD_W-1:0] x0,
                                           input logic [PROD_W-1:0] x1,
                                           input logic [PROD_W-1:0] x2);
    sum3 = {{(DOTW-PROD_W){x0[PROD_W-1]}}, x0}
         + {{(DOTW-PROD_W){x1[PROD_W-1]}}, x1}
         + {{(DOTW-PROD_W){x2[PROD_W-1]}}, x2};
  endfunction

  logic [THR_W-1:0]    thr_q;
  logic [2:0][CW-1:0]  p1_in, q1_in, p2_in, q2_in;

  ctx_t a_d, a_q, b_q, c_d, c_q, f_q, h_d, h_q, k_q, k_in, l_d, l_q, sm_q;
  ctx_t m1_q  [MUL_LAT];
  ctx_t dv1_q [DIV_LAT];
  ctx_t m2_q  [MUL_LAT];
  ctx_t dv2_q [DIV_LAT];

  logic [PROD_W-1:0]   pr_d [5][3];
  logic [PROD_W-1:0]   pr_q [5][3];
  logic [PW-1:0]       ae, bb, bf, ce, bs;
  logic [PW-1:0]       f_den_q, f_num_q, kn_q, e1;
  logic [PW-1:0]       div1_num, div1_den, div2_num, div2_den;
  logic [SW-1:0]       q1, q2;
  logic [SPW-1:0]      sp1_q [3];
  logic [SPW-1:0]      sp2_q [3];
  logic signed [SPW-1:0] sh1 [3];
  logic signed [SPW-1:0] sh2 [3];
  logic [DW-1:0]       c1w [3];
  logic [DW-1:0]       c2w [3];
  logic [DW-1:0]       dc_q [3];
  logic [SQW-1:0]      sq_q [3];
  logic [DOTW-1:0]     dist_sum;
  pt_t                 n_d, n_q, o_q, out_q;
  logic [DIST_W-1:0]   dist_q;

  // never hold off a request: every stage advances every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  assign p1_in = {seg1_start_z_i, seg1_start_y_i, seg1_start_x_i};
  assign q1_in = {seg1_end_z_i, seg1_end_y_i, seg1_end_x_i};
  assign p2_in = {seg2_start_z_i, seg2_start_y_i, seg2_start_x_i};
  assign q2_in = {seg2_end_z_i, seg2_end_y_i, seg2_end_x_i};

  // stage A: direction vectors and offset between start points
  always_comb begin
    a_d     = '0;
    a_d.vld = start && !busy;
    a_d.p1  = p1_in;
    a_d.p2  = p2_in;
    for (int k = 0; k < 3; k++) begin
      a_d.d1[k] = {q1_in[k][CW-1], q1_in[k]} - {p1_in[k][CW-1], p1_in[k]};
      a_d.d2[k] = {q2_in[k][CW-1], q2_in[k]} - {p2_in[k][CW-1], p2_in[k]};
      a_d.r[k]  = {p1_in[k][CW-1], p1_in[k]} - {p2_in[k][CW-1], p2_in[k]};
    end
  end

  // stage B: the fifteen coordinate products of the five dot products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      pr_d[0][k] = $signed(a_q.d1[k]) * $signed(a_q.d1[k]);
      pr_d[1][k] = $signed(a_q.d2[k]) * $signed(a_q.d2[k]);
      pr_d[2][k] = $signed(a_q.d2[k]) * $signed(a_q.r[k]);
      pr_d[3][k] = $signed(a_q.d1[k]) * $signed(a_q.r[k]);
      pr_d[4][k] = $signed(a_q.d1[k]) * $signed(a_q.d2[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 5; j++) begin
      for (int k = 0; k < 3; k++) begin
        pr_q[j][k] <= pr_d[j][k];
      end
    end
  end

  // stage C: dot products and the point tests
  always_comb begin
    c_d      = b_q;
    c_d.a    = sum3(pr_q[0][0], pr_q[0][1], pr_q[0][2]);
    c_d.e    = sum3(pr_q[1][0], pr_q[1][1], pr_q[1][2]);
    c_d.f    = sum3(pr_q[2][0], pr_q[2][1], pr_q[2][2]);
    c_d.c    = sum3(pr_q[3][0], pr_q[3][1], pr_q[3][2]);
    c_d.b    = sum3(pr_q[4][0], pr_q[4][1], pr_q[4][2]);
    c_d.deg1 = c_d.a <= {{(DOTW-THR_W){1'b0}}, thr_q};
    c_d.deg2 = c_d.e <= {{(DOTW-THR_W){1'b0}}, thr_q};
  end

  spcp_mul u_mul_ae (.clk_i(clk_i), .op_a_i(c_q.a), .op_b_i(c_q.e), .prod_o(ae));
  spcp_mul u_mul_bb (.clk_i(clk_i), .op_a_i(c_q.b), .op_b_i(c_q.b), .prod_o(bb));
  spcp_mul u_mul_bf (.clk_i(clk_i), .op_a_i(c_q.b), .op_b_i(c_q.f), .prod_o(bf));
  spcp_mul u_mul_ce (.clk_i(clk_i), .op_a_i(c_q.c), .op_b_i(c_q.e), .prod_o(ce));

  // stage F: denominator and numerator of the unclamped s
  always_ff @(posedge clk_i) begin
    f_den_q <= ae - bb;
    f_num_q <= bf - ce;
  end

  // pick the first quotient's operands; a zero denominator gives s = 0
  always_comb begin
    priority if (f_q.deg1 && f_q.deg2) begin
      div1_num = '0;
      div1_den = PW'(1);
    end else if (f_q.deg1) begin
      div1_num = ext_dot(f_q.f);
      div1_den = ext_dot(f_q.e);
    end else if (f_q.deg2) begin
      div1_num = PW'(0) - ext_dot(f_q.c);
      div1_den = ext_dot(f_q.a);
    end else if (f_den_q == '0) begin
      div1_num = '0;
      div1_den = PW'(1);
    end else begin
      div1_num = f_num_q;
      div1_den = f_den_q;
    end
  end

  spcp_div u_div1 (.clk_i(clk_i), .num_i(div1_num), .den_i(div1_den), .q_o(q1));

  always_comb begin
    h_d    = dv1_q[DIV_LAT-1];
    h_d.q1 = q1;
  end

  spcp_mul u_mul_bs (
    .clk_i  (clk_i),
    .op_a_i (h_q.b),
    .op_b_i ({{(DOTW-SW){1'b0}}, h_q.q1}),
    .prod_o (bs)
  );

  // stage K: numerator of t, scaled by one
  always_ff @(posedge clk_i) begin
    kn_q <= bs + (ext_dot(m2_q[MUL_LAT-1].f) << PF);
  end

  assign e1 = ext_dot(k_q.e) << PF;

  // clamp test on t and operands of the second quotient
  always_comb begin
    k_in     = k_q;
    div2_num = '0;
    div2_den = PW'(1);
    priority if (k_q.deg1 && k_q.deg2) begin
      k_in.sel = SEL_NONE;
    end else if (k_q.deg1) begin
      k_in.sel = SEL_DEG1;
    end else if (k_q.deg2) begin
      k_in.sel = SEL_DEG2;
    end else if (kn_q[PW-1]) begin
      k_in.sel = SEL_T0;
      div2_num = PW'(0) - ext_dot(k_q.c);
      div2_den = ext_dot(k_q.a);
    end else if ($signed(kn_q) > $signed(e1)) begin
      k_in.sel = SEL_T1;
      div2_num = ext_dot(k_q.b) - ext_dot(k_q.c);
      div2_den = ext_dot(k_q.a);
    end else begin
      k_in.sel = SEL_T;
      div2_num = kn_q;
      div2_den = e1;
    end
  end

  spcp_div u_div2 (.clk_i(clk_i), .num_i(div2_num), .den_i(div2_den), .q_o(q2));

  // stage L: final s and t
  always_comb begin
    l_d = dv2_q[DIV_LAT-1];
    unique case (l_d.sel)
      SEL_NONE: begin
        l_d.s = '0;
        l_d.t = '0;
      end
      SEL_DEG1: begin
        l_d.s = '0;
        l_d.t = l_d.q1;
      end
      SEL_DEG2: begin
        l_d.s = l_d.q1;
        l_d.t = '0;
      end
      SEL_T0: begin
        l_d.s = q2;
        l_d.t = '0;
      end
      SEL_T1: begin
        l_d.s = q2;
        l_d.t = ONE;
      end
      SEL_T: begin
        l_d.s = l_d.q1;
        l_d.t = q2;
      end
      default: begin
        l_d.s = '0;
        l_d.t = '0;
      end
    endcase
  end

  // stage M: direction times parameter
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sp1_q[k] <= $signed(l_q.d1[k]) * $signed({1'b0, l_q.s});
      sp2_q[k] <= $signed(l_q.d2[k]) * $signed({1'b0, l_q.t});
    end
  end

  // stage N: floor the scaled directions and add the start points
  always_comb begin
    n_d     = '0;
    n_d.vld = sm_q.vld;
    n_d.s   = sm_q.s;
    n_d.t   = sm_q.t;
    for (int k = 0; k < 3; k++) begin
      sh1[k]    = $signed(sp1_q[k]) >>> PF;
      sh2[k]    = $signed(sp2_q[k]) >>> PF;
      c1w[k]    = {sm_q.p1[k][CW-1], sm_q.p1[k]} + sh1[k][DW-1:0];
      c2w[k]    = {sm_q.p2[k][CW-1], sm_q.p2[k]} + sh2[k][DW-1:0];
      n_d.c1[k] = c1w[k][CW-1:0];
      n_d.c2[k] = c2w[k][CW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      dc_q[k] <= c1w[k] - c2w[k];
    end
  end

  // stage O: squares of the gap
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= $signed(dc_q[k]) * $signed(dc_q[k]);
    end
  end

  // stage P: sum and saturate
  assign dist_sum = {{(DOTW-SQW){1'b0}}, sq_q[0]}
                  + {{(DOTW-SQW){1'b0}}, sq_q[1]}
                  + {{(DOTW-SQW){1'b0}}, sq_q[2]};

  always_ff @(posedge clk_i) begin
    if (dist_sum[DOTW-1:DIST_W] != '0) begin
      dist_q <= '1;
    end else begin
      dist_q <= dist_sum[DIST_W-1:0];
    end
  end

  // context registers: advance every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q   <= '0;
      b_q   <= '0;
      c_q   <= '0;
      f_q   <= '0;
      h_q   <= '0;
      k_q   <= '0;
      l_q   <= '0;
      sm_q  <= '0;
      n_q   <= '0;
      o_q   <= '0;
      out_q <= '0;
      for (int i = 0; i < MUL_LAT; i++) begin
        m1_q[i] <= '0;
        m2_q[i] <= '0;
      end
      for (int i = 0; i < DIV_LAT; i++) begin
        dv1_q[i] <= '0;
        dv2_q[i] <= '0;
      end
    end else begin
      a_q     <= a_d;
      b_q     <= a_q;
      c_q     <= c_d;
      m1_q[0] <= c_q;
      for (int i = 1; i < MUL_LAT; i++) begin
        m1_q[i] <= m1_q[i-1];
        m2_q[i] <= m2_q[i-1];
      end
      f_q      <= m1_q[MUL_LAT-1];
      dv1_q[0] <= f_q;
      dv2_q[0] <= k_in;
      for (int i = 1; i < DIV_LAT; i++) begin
        dv1_q[i] <= dv1_q[i-1];
        dv2_q[i] <= dv2_q[i-1];
      end
      h_q     <= h_d;
      m2_q[0] <= h_q;
      k_q     <= m2_q[MUL_LAT-1];
      l_q     <= l_d;
      sm_q    <= l_q;
      n_q     <= n_d;
      o_q     <= n_q;
      out_q   <= o_q;
    end
  end

  assign result_valid_o     = out_q.vld;
  assign param_s_o          = out_q.s;
  assign param_t_o          = out_q.t;
  assign closest1_x_o       = out_q.c1[0];
  assign closest1_y_o       = out_q.c1[1];
  assign closest1_z_o       = out_q.c1[2];
  assign closest2_x_o       = out_q.c2[0];
  assign closest2_y_o       = out_q.c2[1];
  assign closest2_z_o       = out_q.c2[2];
  assign distance_squared_o = dist_q;

  // first quotient never exceeds one
  a_q1_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv1_q[DIV_LAT-1].vld |-> q1 <= ONE)
    else $error("first quotient above one");

  // the second quotient pipeline invents no requests
  a_div2_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    l_q.vld |-> $past(k_q.vld, DIV_LAT + 1))
    else $error("request appeared out of the second quotient pipeline");

  // a zero parameter puts the closest point on the start point
  a_c1_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q.vld && (n_q.s == '0) |-> n_q.c1 == $past(sm_q.p1))
    else $error("closest point on first segment off its start");

  a_c2_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q.vld && (n_q.t == '0) |-> n_q.c2 == $past(sm_q.p2))
    else $error("closest point on second segment off its start");

  a_param_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (param_s_o <= ONE) && (param_t_o <= ONE))
    else $error("parameter out of range");

endmodule

>>> rtl/spcp_mul.sv
`timescale 1ns / 1ps
module spcp_mul (
  input  logic                     clk_i,
  input  logic [spcp_pkg::DOTW-1:0] op_a_i,
  input  logic [spcp_pkg::DOTW-1:0] op_b_i,
  output logic [spcp_pkg::PW-1:0]   prod_o
);
  import spcp_pkg::*;

  logic [HW-1:0]          a_lo, b_lo;
  logic signed [HW-1:0]   a_hi, b_hi;
  logic [2*HW-1:0]        pp_ll_q;
  logic signed [2*HW:0]   pp_lh_q, pp_hl_q;
  logic signed [2*HW-1:0] pp_hh_q;
  logic [PW-1:0]          ll_x, lh_x, hl_x, hh_x, prod_d, prod_q;

  assign a_lo = op_a_i[HW-1:0];
  assign b_lo = op_b_i[HW-1:0];
  assign a_hi = $signed(op_a_i[DOTW-1:HW]);
  assign b_hi = $signed(op_b_i[DOTW-1:HW]);

  // stage one: four partial products of half width
  always_ff @(posedge clk_i) begin
    pp_ll_q <= a_lo * b_lo;
    pp_lh_q <= $signed({1'b0, a_lo}) * b_hi;
    pp_hl_q <= a_hi * $signed({1'b0, b_lo});
    pp_hh_q <= a_hi * b_hi;
  end

  // stage two: align and add
  assign ll_x = {{(PW-2*HW){1'b0}}, pp_ll_q};
  assign lh_x = {{(PW-2*HW-1){pp_lh_q[2*HW]}}, pp_lh_q};
  assign hl_x = {{(PW-2*HW-1){pp_hl_q[2*HW]}}, pp_hl_q};
  assign hh_x = {{(PW-2*HW){pp_hh_q[2*HW-1]}}, pp_hh_q};
  assign prod_d = (hh_x << (2*HW)) + ((lh_x + hl_x) << HW) + ll_x;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/spcp_div.sv
`timescale 1ns / 1ps
module spcp_div (
  input  logic                   clk_i,
  input  logic [spcp_pkg::PW-1:0] num_i,
  input  logic [spcp_pkg::PW-1:0] den_i,
  output logic [spcp_pkg::SW-1:0] q_o
);
  import spcp_pkg::*;

  logic [PW-1:0] rem_q [DIV_LAT];
  logic [PW-1:0] den_q [DIV_LAT];
  logic [PF-1:0] quo_q [DIV_LAT];
  logic          zf_q  [DIV_LAT];
  logic          of_q  [DIV_LAT];

  // front stage: settle the clamped cases
  always_ff @(posedge clk_i) begin
    zf_q[0]  <= num_i[PW-1] || (num_i == '0);
    of_q[0]  <= $signed(num_i) >= $signed(den_i);
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
  end

  // one restoring step per stage
  for (genvar i = 1; i < DIV_LAT; i++) begin : g_step
    logic [PW:0] r2;
    logic        take;
    assign r2   = {rem_q[i-1], 1'b0};
    assign take = r2 >= {1'b0, den_q[i-1]};
    always_ff @(posedge clk_i) begin
      rem_q[i] <= take ? PW'(r2 - {1'b0, den_q[i-1]}) : r2[PW-1:0];
      den_q[i] <= den_q[i-1];
      quo_q[i] <= {quo_q[i-1][PF-2:0], take};
      zf_q[i]  <= zf_q[i-1];
      of_q[i]  <= of_q[i-1];
    end
  end

  assign q_o = zf_q[DIV_LAT-1] ? '0 :
               of_q[DIV_LAT-1] ? ONE : {1'b0, quo_q[DIV_LAT-1]};

endmodule

>>> test/segment_pair_closest_points_tb.sv
`timescale 1ns / 1ps
module segment_pair_closest_points_tb;
  import spcp_pkg::*;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef logic signed [191:0] wide_t;

  // One request: P1, Q1, P2, Q2, three coordinates each.
  typedef struct {
    logic signed [CW-1:0] v [12];
  } seg_pair_t;

  typedef struct {
    logic [SW-1:0]        s;
    logic [SW-1:0]        t;
    logic signed [CW-1:0] c1 [3];
    logic signed [CW-1:0] c2 [3];
    logic [DIST_W-1:0]    dist_sq;
  } closest_t;

  // Scoreboard: predicts the closest-point answer per request and holds the
  // answers until the block returns them.
  class closest_scoreboard;
    closest_t          pending[$];
    logic [THR_W-1:0]  threshold;
    int                errors;
    int                checked;

    function new();
      threshold = '0;
      errors    = 0;
      checked   = 0;
    endfunction

    // Clamped quotient in Q1.16; den is positive.
    function logic [SW-1:0] clamp_quot(wide_t num, wide_t den);
      wide_t q;
      if (num <= 0) return '0;
      if (num >= den) return ONE;
      q = (num <<< PF) / den;
      return q[SW-1:0];
    endfunction

    // Scale a difference by a parameter, rounding toward minus infinity.
    function longint scale_down(longint d, logic [SW-1:0] p);
      longint prod;
      prod = d * longint'({1'b0, p});
      return prod >>> PF;
    endfunction

    function closest_t closest_pair(seg_pair_t r);
      closest_t      o;
      longint        p1[3], d1[3], p2[3], d2[3], rr[3], c1v, c2v, dc;
      wide_t         a, e, f, c, b, denom, n, e1, dist_sq, thr;
      logic [SW-1:0] s, t;
      a = 0; e = 0; f = 0; c = 0; b = 0; dist_sq = 0;
      for (int i = 0; i < 3; i++) begin
        p1[i] = longint'(r.v[i]);
        d1[i] = longint'(r.v[3+i]) - p1[i];
        p2[i] = longint'(r.v[6+i]);
        d2[i] = longint'(r.v[9+i]) - p2[i];
        rr[i] = p1[i] - p2[i];
        a += wide_t'(d1[i] * d1[i]);
        e += wide_t'(d2[i] * d2[i]);
        f += wide_t'(d2[i] * rr[i]);
        c += wide_t'(d1[i] * rr[i]);
        b += wide_t'(d1[i] * d2[i]);
      end
      thr = wide_t'({1'b0, threshold});
      if (thr >= a && thr >= e) begin
        s = '0;
        t = '0;
      end else if (thr >= a) begin
        s = '0;
        t = clamp_quot(f, e);
      end else if (thr >= e) begin
        t = '0;
        s = clamp_quot(-c, a);
      end else begin
        denom = a * e - b * b;
        // parallel segments: start from s = 0
        s = (denom == 0) ? '0 : clamp_quot(b * f - c * e, denom);
        n = b * wide_t'({1'b0, s}) + (f <<< PF);
        e1 = e <<< PF;
        if (n < 0) begin
          t = '0;
          s = clamp_quot(-c, a);
        end else if (n > e1) begin
          t = ONE;
          s = clamp_quot(b - c, a);
        end else begin
          t = clamp_quot(n, e1);
        end
      end
      for (int i = 0; i < 3; i++) begin
        c1v = p1[i] + scale_down(d1[i], s);
        c2v = p2[i] + scale_down(d2[i], t);
        o.c1[i] = c1v[CW-1:0];
        o.c2[i] = c2v[CW-1:0];
        dc = c1v - c2v;
        dist_sq += wide_t'(dc) * wide_t'(dc);
      end
      o.s       = s;
      o.t       = t;
      o.dist_sq = (dist_sq > wide_t'({1'b0, DIST_MAX})) ? DIST_MAX : dist_sq[DIST_W-1:0];
      return o;
    endfunction

    function void note_request(seg_pair_t r);
      pending.push_back(closest_pair(r));
    endfunction

    function void field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(closest_t got);
      closest_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, expected none, got s=%0h t=%0h",
                 $time, got.s, got.t);
        return;
      end
      want = pending.pop_front();
      checked++;
      field("param_s", want.s, got.s);
      field("param_t", want.t, got.t);
      for (int i = 0; i < 3; i++) begin
        field($sformatf("closest1[%0d]", i), want.c1[i], got.c1[i]);
        field($sformatf("closest2[%0d]", i), want.c2[i], got.c2[i]);
      end
      field("distance_squared", want.dist_sq, got.dist_sq);
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [THR_W-1:0]     cfg_wdata_i = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CW-1:0] coord [12] = '{default: '0};
  logic                 result_valid_o;
  logic [SW-1:0]        param_s_o, param_t_o;
  logic signed [CW-1:0] closest1_x_o, closest1_y_o, closest1_z_o;
  logic signed [CW-1:0] closest2_x_o, closest2_y_o, closest2_z_o;
  logic [DIST_W-1:0]    distance_squared_o;

  closest_scoreboard sb = new();
  int                requests_sent = 0;

  always #5 clk_i = ~clk_i;

  segment_pair_closest_points DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .start              (start),
    .busy               (busy),
    .seg1_start_x_i     (coord[0]),
    .seg1_start_y_i     (coord[1]),
    .seg1_start_z_i     (coord[2]),
    .seg1_end_x_i       (coord[3]),
    .seg1_end_y_i       (coord[4]),
    .seg1_end_z_i       (coord[5]),
    .seg2_start_x_i     (coord[6]),
    .seg2_start_y_i     (coord[7]),
    .seg2_start_z_i     (coord[8]),
    .seg2_end_x_i       (coord[9]),
    .seg2_end_y_i       (coord[10]),
    .seg2_end_z_i       (coord[11]),
    .result_valid_o     (result_valid_o),
    .param_s_o          (param_s_o),
    .param_t_o          (param_t_o),
    .closest1_x_o       (closest1_x_o),
    .closest1_y_o       (closest1_y_o),
    .closest1_z_o       (closest1_z_o),
    .closest2_x_o       (closest2_x_o),
    .closest2_y_o       (closest2_y_o),
    .closest2_z_o       (closest2_z_o),
    .distance_squared_o (distance_squared_o)
  );

  // Watch both sides at each edge; inputs change only by nonblocking
  // assignment, so the values read here are the ones the block saw.
  always @(posedge clk_i) begin
    seg_pair_t req;
    closest_t  got;
    if (rst_ni && start && !busy) begin
      for (int i = 0; i < 12; i++) req.v[i] = coord[i];
      sb.note_request(req);
    end
    if (rst_ni && result_valid_o) begin
      got.s       = param_s_o;
      got.t       = param_t_o;
      got.c1[0]   = closest1_x_o;
      got.c1[1]   = closest1_y_o;
      got.c1[2]   = closest1_z_o;
      got.c2[0]   = closest2_x_o;
      got.c2[1]   = closest2_y_o;
      got.c2[2]   = closest2_z_o;
      got.dist_sq = distance_squared_o;
      sb.check_result(got);
    end
  end

  // Issue one request, idling first with the given chance per cycle, and
  // hold it until the block takes it. start stays high afterwards so the
  // next request can follow back to back.
  task automatic send_request(seg_pair_t r, int idle_pct);
    logic was_busy;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    for (int i = 0; i < 12; i++) coord[i] <= r.v[i];
    do begin
      @(negedge clk_i);
      was_busy = busy;
      @(posedge clk_i);
    end while (was_busy);
    requests_sent++;
  endtask

  // Drain the pipeline, then write the threshold while idle.
  task automatic write_threshold(logic [THR_W-1:0] value);
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.threshold = value;
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    return CW'($urandom);
  endfunction

  function automatic logic signed [CW-1:0] near(logic signed [CW-1:0] base, int span);
    return base + CW'($urandom_range(2 * span) - span);
  endfunction

  // Random pair, biased toward degenerate and parallel segments and toward
  // nearby endpoints, where clamping of s and t is frequent.
  function automatic seg_pair_t random_pair();
    seg_pair_t r;
    int        kind, span, k;
    kind = $urandom_range(9);
    span = ($urandom_range(1)) ? 4096 : 200;
    for (int i = 0; i < 12; i++) r.v[i] = rand_coord();
    case (kind)
      4, 5: begin
        for (int i = 3; i < 12; i++) r.v[i] = near(r.v[i % 3], span);
      end
      6: begin
        for (int i = 0; i < 3; i++) r.v[3+i] = near(r.v[i], $urandom_range(150));
      end
      7: begin
        for (int i = 0; i < 3; i++) r.v[9+i] = near(r.v[6+i], $urandom_range(150));
      end
      8: begin
        // second direction a whole multiple of the first, either sense
        k = $urandom_range(3) - 2;
        if (k == 0) k = 1;
        for (int i = 0; i < 3; i++) begin
          r.v[3+i] = near(r.v[i], span);
          r.v[6+i] = near(r.v[i], span);
          r.v[9+i] = r.v[6+i] + CW'(k) * (r.v[3+i] - r.v[i]);
        end
      end
      9: begin
        for (int i = 0; i < 3; i++) begin
          r.v[3+i] = near(r.v[i], 1);
          r.v[9+i] = near(r.v[6+i], 1);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic seg_pair_t make_pair(int x1, int y1, int z1, int x2, int y2, int z2,
                                          int x3, int y3, int z3, int x4, int y4, int z4);
    seg_pair_t r;
    int        vals [12];
    vals = '{x1, y1, z1, x2, y2, z2, x3, y3, z3, x4, y4, z4};
    for (int i = 0; i < 12; i++) r.v[i] = CW'(vals[i]);
    return r;
  endfunction

  task automatic run_random(int count, int idle_pct);
    for (int n = 0; n < count; n++) send_request(random_pair(), idle_pct);
  endtask

  initial begin
    seg_pair_t dir [$];
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, degenerate cases, parallel lines, clamping of t.
    dir.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(make_pair(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                            8388607, -8388608, 8388607, -8388608, 8388607, -8388608));
    dir.push_back(make_pair(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                            8388607, 8388607, 8388607, -8388608, -8388608, -8388608));
    dir.push_back(make_pair(-8388608, 0, 0, -8388608, 0, 0, 8388607, 0, 0, 8388607, 0, 0));
    dir.push_back(make_pair(256, 256, 256, 256, 256, 256, 0, 0, 0, 512, 0, 0));
    dir.push_back(make_pair(0, 0, 0, 512, 0, 0, 256, 256, 256, 256, 256, 256));
    dir.push_back(make_pair(0, 0, 0, 256, 0, 0, 0, 256, 0, 256, 256, 0));
    dir.push_back(make_pair(0, 0, 0, 256, 0, 0, 256, 0, 0, 0, 0, 0));
    dir.push_back(make_pair(0, 0, 0, 1024, 0, 0, 2048, 256, 0, 4096, 256, 0));
    dir.push_back(make_pair(0, 0, 0, 1024, 0, 0, -4096, 256, 0, -2048, 256, 0));
    dir.push_back(make_pair(0, -512, 0, 0, 512, 0, -512, 0, 256, 512, 0, 256));
    dir.push_back(make_pair(0, 0, 0, 1024, 0, 0, 512, -2048, 256, 512, -1024, 256));
    dir.push_back(make_pair(0, 0, 0, 1024, 0, 0, 512, 1024, 256, 512, 2048, 256));
    dir.push_back(make_pair(0, 0, 0, 1024, 0, 0, -2048, -512, 0, -1024, 512, 0));
    dir.push_back(make_pair(0, 0, 0, 1024, 0, 0, 3072, -512, 0, 2048, 512, 0));
    dir.push_back(make_pair(-3, 7, 1, 1, 0, -5, 2, 2, 2, -9, 4, 3));
    dir.push_back(make_pair(0, 0, 0, 1, 0, 0, 0, 1, 0, 0, 1, 1));
    dir.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
    foreach (dir[i]) send_request(dir[i], 22);

    run_random(280, 22);
    write_threshold(16'hFFFF);
    run_random(300, 73);
    write_threshold(16'(256 + $urandom_range(20000)));
    run_random(300, 0);
    write_threshold(16'd1);
    run_random(300, 0);

    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Sent %0d segment pairs over four threshold settings and three idle mixes.",
             requests_sent);
    $display("Checked %0d results, %0d field mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d results outstanding.", sb.pending.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
